// ----- src/brb_pkg.sv -----
// shared types and constants for the byte ring buffer with pointer moves
// no dependencies; used by brb_ctrl, brb_datapath and the top level
package brb_pkg;

    localparam int DEPTH = 1024;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int USED_W = PTR_W + 1;
    localparam int CNT_W = 11;
    localparam int MAG_W = 17;

    typedef enum logic [2:0] {
        ACT_WRITE    = 3'd0,
        ACT_READ     = 3'd1,
        ACT_PEEK     = 3'd2,
        ACT_MOVE_RD  = 3'd3,
        ACT_MOVE_WR  = 3'd4,
        ACT_CLEAR    = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

// ----- src/brb_ctrl.sv -----
// controller state machine: load, execute, respond
// depends on brb_pkg
module brb_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          result_valid,
    output brb_pkg::cmd_t cmd
);

    brb_pkg::state_t state_reg;
    brb_pkg::state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = brb_pkg::ST_EXEC;
                end
            end
            brb_pkg::ST_EXEC:
            begin
                state_next = brb_pkg::ST_RESP;
            end
            brb_pkg::ST_RESP:
            begin
                state_next = brb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = brb_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // outputs and commands
    assign busy         = (state_reg != brb_pkg::ST_IDLE);
    assign result_valid = (state_reg == brb_pkg::ST_RESP);
    assign cmd.load     = (state_reg == brb_pkg::ST_IDLE) && start;
    assign cmd.exec     = (state_reg == brb_pkg::ST_EXEC);

    // checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.exec)
        else $error("accepted beat not executed next cycle");

    a_exec_resp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (result_valid && busy))
        else $error("execute not followed by result");

endmodule

// ----- src/brb_datapath.sv -----
// datapath: byte store, pointers, full flag and result registers
// depends on brb_pkg; driven by brb_ctrl commands
module brb_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  brb_pkg::cmd_t               cmd,
    input  logic [2:0]                  action,
    input  logic [7:0]                  write_byte,
    input  logic [9:0]                  peek_offset,
    input  logic signed [16:0]          move_amount,
    output logic [7:0]                  read_byte,
    output logic [brb_pkg::CNT_W-1:0]   done_count,
    output logic [brb_pkg::CNT_W-1:0]   readable_count,
    output logic [brb_pkg::CNT_W-1:0]   writable_count
);

    localparam int PTR_W  = brb_pkg::PTR_W;
    localparam int USED_W = brb_pkg::USED_W;
    localparam int MAG_W  = brb_pkg::MAG_W;
    localparam int CNT_W  = brb_pkg::CNT_W;

    // captured beat
    logic [2:0]        act_reg;
    logic [7:0]        wbyte_reg;
    logic [9:0]        offset_reg;
    logic [MAG_W-1:0]  move_reg;

    // buffer state
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic              full_reg, full_next;

    // result registers
    logic [CNT_W-1:0]  done_reg, done_next;
    logic              rbyte_en_reg, rbyte_en_next;
    logic [7:0]        mem_q_reg;

    // byte store
    logic [7:0]        mem [brb_pkg::DEPTH];

    logic [USED_W-1:0] used;
    logic [USED_W-1:0] space;
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [PTR_W-1:0]  mag_lo;
    logic              mag_ge_used;
    logic              mag_ge_space;
    logic              mem_we;
    logic [PTR_W-1:0]  rd_addr;
    logic [PTR_W-1:0]  wp_inc;

    // capture the beat on accept
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg    <= action;
            wbyte_reg  <= write_byte;
            offset_reg <= peek_offset;
            move_reg   <= unsigned'(move_amount);
        end
    end

    // occupancy and move magnitude
    always_comb
    begin
        used         = full_reg ? USED_W'(brb_pkg::DEPTH) : {1'b0, wp_reg - rp_reg};
        space        = USED_W'(brb_pkg::DEPTH) - used;
        neg          = move_reg[MAG_W-1];
        mag          = neg ? (~move_reg + MAG_W'(1)) : move_reg;
        mag_lo       = mag[PTR_W-1:0];
        mag_ge_used  = (mag >= MAG_W'(used));
        mag_ge_space = (mag >= MAG_W'(space));
        wp_inc       = wp_reg + PTR_W'(1);
    end

    // action decode and pointer update
    always_comb
    begin
        rp_next       = rp_reg;
        wp_next       = wp_reg;
        full_next     = full_reg;
        done_next     = '0;
        rbyte_en_next = 1'b0;
        mem_we        = 1'b0;
        rd_addr       = rp_reg;
        case (act_reg)
            brb_pkg::ACT_WRITE:
            begin
                if (!full_reg)
                begin
                    mem_we    = 1'b1;
                    wp_next   = wp_inc;
                    full_next = (wp_inc == rp_reg);
                    done_next = CNT_W'(1);
                end
            end
            brb_pkg::ACT_READ:
            begin
                if (used != '0)
                begin
                    rbyte_en_next = 1'b1;
                    done_next     = CNT_W'(1);
                    if (used == USED_W'(1))
                    begin
                        rp_next   = '0;
                        wp_next   = '0;
                        full_next = 1'b0;
                    end
                    else
                    begin
                        rp_next   = rp_reg + PTR_W'(1);
                        full_next = 1'b0;
                    end
                end
            end
            brb_pkg::ACT_PEEK:
            begin
                rd_addr = rp_reg + PTR_W'(offset_reg);
                if (USED_W'(offset_reg) < used)
                begin
                    rbyte_en_next = 1'b1;
                    done_next     = CNT_W'(1);
                end
            end
            brb_pkg::ACT_MOVE_RD:
            begin
                if (mag != '0)
                begin
                    if (!neg)
                    begin
                        if (used != '0)
                        begin
                            if (mag_ge_used)
                            begin
                                rp_next   = '0;
                                wp_next   = '0;
                                full_next = 1'b0;
                                done_next = CNT_W'(used);
                            end
                            else
                            begin
                                rp_next   = rp_reg + mag_lo;
                                full_next = 1'b0;
                                done_next = CNT_W'(mag_lo);
                            end
                        end
                    end
                    else if (space != '0)
                    begin
                        if (mag_ge_space)
                        begin
                            rp_next   = wp_reg;
                            full_next = 1'b1;
                            done_next = CNT_W'(space);
                        end
                        else
                        begin
                            rp_next   = rp_reg - mag_lo;
                            done_next = CNT_W'(mag_lo);
                        end
                    end
                end
            end
            brb_pkg::ACT_MOVE_WR:
            begin
                if (mag != '0)
                begin
                    if (!neg)
                    begin
                        if (space != '0)
                        begin
                            if (mag_ge_space)
                            begin
                                wp_next   = rp_reg;
                                full_next = 1'b1;
                                done_next = CNT_W'(space);
                            end
                            else
                            begin
                                wp_next   = wp_reg + mag_lo;
                                done_next = CNT_W'(mag_lo);
                            end
                        end
                    end
                    else if (used != '0)
                    begin
                        if (mag_ge_used)
                        begin
                            rp_next   = '0;
                            wp_next   = '0;
                            full_next = 1'b0;
                            done_next = CNT_W'(used);
                        end
                        else
                        begin
                            wp_next   = wp_reg - mag_lo;
                            full_next = 1'b0;
                            done_next = CNT_W'(mag_lo);
                        end
                    end
                end
            end
            brb_pkg::ACT_CLEAR:
            begin
                rp_next   = '0;
                wp_next   = '0;
                full_next = 1'b0;
            end
            default:
            begin
                rp_next = rp_reg;
            end
        endcase
    end

    // pointer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg       <= '0;
            wp_reg       <= '0;
            full_reg     <= 1'b0;
            done_reg     <= '0;
            rbyte_en_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            full_reg     <= full_next;
            done_reg     <= done_next;
            rbyte_en_reg <= rbyte_en_next;
        end
    end

    // byte store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            mem[wp_reg] <= wbyte_reg;
        end
        if (cmd.exec)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // result fields
    assign read_byte      = rbyte_en_reg ? mem_q_reg : 8'd0;
    assign done_count     = done_reg;
    assign readable_count = CNT_W'(used);
    assign writable_count = CNT_W'(space);

    // checks
    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (rp_reg == wp_reg))
        else $error("full flag set with pointers apart");

    a_hold_rp: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> ($stable(rp_reg) && $stable(wp_reg) && $stable(full_reg)))
        else $error("buffer state changed outside execute");

    a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rbyte_en_reg |-> (done_reg == CNT_W'(1)))
        else $error("byte returned without a count of one");

endmodule

// ----- src/byte_ring_buffer_with_pointer_moves_top.sv -----
// top level of the byte ring buffer with pointer moves
// depends on brb_pkg, brb_ctrl and brb_datapath
//
//  channel   handshake              payload
//  command   start & !busy          action, write_byte, peek_offset, move_amount
//  result    result_valid (1 cyc)   read_byte, done_count, readable_count,
//                                   writable_count
//
// every beat passes through capture, execute (store access and pointer update)
// and result; busy is high in execute and result, and result_valid in result
// the byte store read port is registered, which sets the execute-to-result step
// the next command is accepted in the cycle after result_valid
// rst_n clears pointers and full flag at once; store contents stay undefined
// the result cannot be stalled: result_valid is high for one cycle only
module byte_ring_buffer_with_pointer_moves_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  action,
    input  logic [7:0]                  write_byte,
    input  logic [9:0]                  peek_offset,
    input  logic signed [16:0]          move_amount,
    output logic                        result_valid,
    output logic [7:0]                  read_byte,
    output logic [brb_pkg::CNT_W-1:0]   done_count,
    output logic [brb_pkg::CNT_W-1:0]   readable_count,
    output logic [brb_pkg::CNT_W-1:0]   writable_count
);

    brb_pkg::cmd_t cmd;

    // controller
    brb_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    // datapath
    brb_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .action         (action),
        .write_byte     (write_byte),
        .peek_offset    (peek_offset),
        .move_amount    (move_amount),
        .read_byte      (read_byte),
        .done_count     (done_count),
        .readable_count (readable_count),
        .writable_count (writable_count)
    );

endmodule
